### rtl/mqtt_control_packet_parser_macros.svh
// Assertion macros for the MQTT control packet parser.
// No dependencies; included by files that carry assertions.
`ifndef MQTT_CONTROL_PACKET_PARSER_MACROS_SVH
`define MQTT_CONTROL_PACKET_PARSER_MACROS_SVH
// Implication checked on every clock, masked while in reset.
`define MCPP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define MCPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/mqttp_pkg.sv
// Shared types and constants for the MQTT control packet parser.
// No dependencies.
package mqttp_pkg;
  localparam int unsigned LengthBytesDef = 4;
  localparam int unsigned QDepth = 2;

  typedef enum logic [3:0] {
    EV_HEADER = 4'd0, EV_CONFLAGS = 4'd1, EV_KEEPALIVE = 4'd2, EV_PKTID = 4'd3,
    EV_STRLEN = 4'd4, EV_STRBYTE = 4'd5, EV_PAYLOAD = 4'd6, EV_QOS = 4'd7,
    EV_LENERR = 4'd8, EV_UNSUP = 4'd9, EV_SKIPPED = 4'd10
  } event_e;

  typedef enum logic [3:0] {
    PH_HDR, PH_LEN, PH_SKIP, PH_PRE, PH_CFLAGS, PH_KA_HI, PH_KA_LO, PH_SLEN_HI,
    PH_SLEN_LO, PH_SBYTES, PH_PID_HI, PH_PID_LO, PH_PAYLOAD, PH_QOS
  } phase_e;

  localparam logic [3:0] TypeConnect = 4'd1;
  localparam logic [3:0] TypePublish = 4'd3;
  localparam logic [3:0] TypeSubscribe = 4'd8;
  localparam logic [3:0] TypeUnsub = 4'd10;

  localparam logic [2:0] KindTopic = 3'd5;
  localparam logic [2:0] KindFilter = 3'd6;

  typedef struct packed {
    logic        last;
    logic [7:0]  byte_value;
    logic [2:0]  string_kind;
    logic [27:0] field_value;
    logic [3:0]  header_flags;
    logic [3:0]  packet_type;
    event_e      event_res;
  } result_t;
endpackage

### rtl/mqttp_front.sv
// Front part: accepts stream bytes and parses them into result items.
// Depends on mqttp_pkg.
module mqttp_front import mqttp_pkg::*; #(
  parameter int unsigned LengthBytes = LengthBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output logic       byte_ready_o,
  output logic       res_valid_o,
  output result_t    res_o,
  input  logic       res_ready_i
);
  localparam int unsigned IdxW = $clog2(LengthBytes + 1);

  phase_e      phase_q, phase_d;
  logic [3:0]  type_q, type_d, flags_q, flags_d;
  logic [27:0] left_q, left_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]  cflags_q, cflags_d, hi_q, hi_d;
  logic [15:0] sleft_q, sleft_d;
  logic [2:0]  kind_q, kind_d;
  logic        take;
  logic        emit;
  result_t     r;
  logic [27:0] len_new, left_dec;
  logic [15:0] slen;

  assign byte_ready_o = res_ready_i;
  assign take = byte_valid_i && res_ready_i;
  assign res_valid_o = take && emit;
  assign res_o = r;

  // Pick first enabled CONNECT string at or after kind k.
  function automatic logic [3:0] next_str(input logic [2:0] k, input logic [7:0] f);
    logic [3:0] res;
    res = 4'h8;
    if (k == 3'd0) res = 4'd0;
    else if (k <= 3'd2 && f[2]) res = {1'b0, k};
    else if (k <= 3'd3 && f[7]) res = 4'd3;
    else if (k <= 3'd4 && f[6]) res = 4'd4;
    return res;
  endfunction

  always_comb begin
    len_new = left_q;
    for (int i = 0; i < LengthBytes; i++) begin
      if (idx_q == IdxW'(i)) len_new = left_q | (28'(byte_i[6:0]) << (7 * i));
    end
  end
  assign left_dec = (left_q != 28'd0) ? left_q - 28'd1 : 28'd0;
  assign slen = {hi_q, byte_i};

  // Next state and result.
  always_comb begin
    logic [3:0] ns;
    phase_d = phase_q; type_d = type_q; flags_d = flags_q; left_d = left_q;
    idx_d = idx_q; cflags_d = cflags_q; hi_d = hi_q; sleft_d = sleft_q;
    kind_d = kind_q; emit = 1'b0;
    r = '0;
    r.packet_type = type_q;
    r.header_flags = flags_q;
    ns = 4'd0;
    case (phase_q)
      PH_HDR: begin
        type_d = byte_i[7:4]; flags_d = byte_i[3:0]; left_d = '0; idx_d = '0;
        phase_d = PH_LEN;
        r.packet_type = byte_i[7:4]; r.header_flags = byte_i[3:0];
      end
      PH_LEN: begin
        if (idx_q >= IdxW'(LengthBytes)) begin
          emit = 1'b1; r.event_res = EV_LENERR; r.field_value = left_q;
          r.byte_value = byte_i; r.last = 1'b1; phase_d = PH_HDR;
        end else begin
          left_d = len_new; idx_d = idx_q + 1'b1;
          if (!byte_i[7]) begin
            emit = 1'b1; r.field_value = len_new; r.event_res = EV_HEADER;
            case (type_q)
              4'd1: begin phase_d = PH_PRE; sleft_d = 16'd7; end
              4'd3: begin kind_d = KindTopic; phase_d = PH_SLEN_HI; end
              4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd10: phase_d = PH_PID_HI;
              4'd12, 4'd13, 4'd14: phase_d = PH_SKIP;
              default: begin r.event_res = EV_UNSUP; phase_d = PH_SKIP; end
            endcase
            if (len_new == 28'd0) begin r.last = 1'b1; phase_d = PH_HDR; end
          end
        end
      end
      default: begin
        case (phase_q)
          PH_PRE: begin
            if (sleft_q != 16'd0) sleft_d = sleft_q - 16'd1;
            if (sleft_q <= 16'd1) phase_d = PH_CFLAGS;
          end
          PH_CFLAGS: begin
            cflags_d = byte_i; emit = 1'b1; r.event_res = EV_CONFLAGS;
            r.field_value = 28'(byte_i); phase_d = PH_KA_HI;
          end
          PH_KA_HI, PH_SLEN_HI, PH_PID_HI: begin
            hi_d = byte_i;
            phase_d = (phase_q == PH_KA_HI) ? PH_KA_LO :
                      (phase_q == PH_SLEN_HI) ? PH_SLEN_LO : PH_PID_LO;
          end
          PH_KA_LO: begin
            emit = 1'b1; r.event_res = EV_KEEPALIVE; r.field_value = 28'(slen);
            phase_d = PH_SLEN_HI; kind_d = 3'd0;
          end
          PH_SLEN_LO, PH_SBYTES: begin
            emit = 1'b1; r.string_kind = kind_q;
            if (phase_q == PH_SLEN_LO) begin
              sleft_d = slen; r.event_res = EV_STRLEN; r.field_value = 28'(slen);
            end else begin
              sleft_d = (sleft_q != 16'd0) ? sleft_q - 16'd1 : 16'd0;
              r.event_res = EV_STRBYTE; r.byte_value = byte_i;
            end
            phase_d = PH_SBYTES;
            if (sleft_d == 16'd0) begin
              // string finished
              if (type_q == TypeConnect) begin
                ns = next_str(kind_q + 3'd1, cflags_q);
                if (ns[3]) phase_d = PH_SKIP;
                else begin kind_d = ns[2:0]; phase_d = PH_SLEN_HI; end
              end else if (type_q == TypePublish)
                phase_d = (flags_q[2:1] != 2'd0) ? PH_PID_HI : PH_PAYLOAD;
              else if (type_q == TypeSubscribe) phase_d = PH_QOS;
              else if (type_q == TypeUnsub) begin
                kind_d = KindFilter; phase_d = PH_SLEN_HI;
              end else phase_d = PH_SKIP;
            end
          end
          PH_PID_LO: begin
            emit = 1'b1; r.event_res = EV_PKTID; r.field_value = 28'(slen);
            if (type_q == TypePublish) phase_d = PH_PAYLOAD;
            else if (type_q == TypeSubscribe || type_q == TypeUnsub) begin
              kind_d = KindFilter; phase_d = PH_SLEN_HI;
            end else phase_d = PH_SKIP;
          end
          PH_PAYLOAD: begin
            emit = 1'b1; r.event_res = EV_PAYLOAD; r.byte_value = byte_i;
          end
          PH_QOS: begin
            emit = 1'b1; r.event_res = EV_QOS; r.field_value = 28'(byte_i);
            kind_d = KindFilter; phase_d = PH_SLEN_HI;
          end
          default: begin
            phase_d = PH_SKIP; emit = 1'b1; r.event_res = EV_SKIPPED;
            r.byte_value = byte_i;
          end
        endcase
        left_d = left_dec;
        if (left_dec == 28'd0) begin
          r.last = 1'b1; phase_d = PH_HDR;
          if (!emit) begin
            emit = 1'b1; r.event_res = EV_SKIPPED; r.byte_value = byte_i;
          end
        end
      end
    endcase
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR; type_q <= '0; flags_q <= '0; left_q <= '0; idx_q <= '0;
      cflags_q <= '0; hi_q <= '0; sleft_q <= '0; kind_q <= '0;
    end else if (take) begin
      phase_q <= phase_d; type_q <= type_d; flags_q <= flags_d; left_q <= left_d;
      idx_q <= idx_d; cflags_q <= cflags_d; hi_q <= hi_d; sleft_q <= sleft_d;
      kind_q <= kind_d;
    end
  end
endmodule

### rtl/mqttp_queue.sv
// Short result queue between front and back.
// Depends on mqttp_pkg.
module mqttp_queue import mqttp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_valid_i,
  input  result_t wr_data_i,
  output logic    wr_ready_o,
  output logic    rd_valid_o,
  output result_t rd_data_o,
  input  logic    rd_ready_i
);
  result_t   mem_q [QDepth];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  logic      wr, rd;

  assign wr_ready_o = (cnt_q != 2'(QDepth));
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

### rtl/mqttp_back.sv
// Back part: output register stage that drives the result stream.
// Depends on mqttp_pkg.
module mqttp_back import mqttp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  result_t in_data_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output result_t out_data_o,
  input  logic    out_ready_i
);
  logic    vld_q;
  result_t dat_q;

  assign in_ready_o = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_data_o = dat_q;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (in_ready_o) vld_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) dat_q <= in_data_i;
  end
endmodule

### rtl/mqtt_control_packet_parser.sv
// MQTT control packet parser top level: takes one byte per cycle while the result queue has room.
// Each result is registered in a queue entry and then in the output register before it appears.
// Throughput: one byte per cycle while the queue has room, as the parser handles each byte when it is taken.
// A 2-entry queue and an output register decouple input from output stalls.
// Reset (rst_ni low, async) returns the parser to waiting for a header.
// Depends on mqttp_pkg, mqttp_front, mqttp_queue, mqttp_back, macros header.
`include "mqtt_control_packet_parser_macros.svh"
module mqtt_control_packet_parser import mqttp_pkg::*; #(
  parameter int unsigned LengthBytes = LengthBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,
  // [3:0] event_res, [7:4] packet_type, [11:8] header_flags,
  // [39:12] field_value, [42:40] string_kind, [50:43] byte_value, zeros above
  output logic        m_axis_tlast    // packet_last
);
  logic    f_valid, q_ready, q_valid, b_ready, b_valid;
  result_t f_res, q_res, b_res;

  mqttp_front #(.LengthBytes(LengthBytes)) u_front (
    .clk_i, .rst_ni, .byte_valid_i(s_axis_tvalid), .byte_i(s_axis_tdata),
    .byte_ready_o(s_axis_tready), .res_valid_o(f_valid), .res_o(f_res),
    .res_ready_i(q_ready)
  );
  mqttp_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_data_i(f_res), .wr_ready_o(q_ready),
    .rd_valid_o(q_valid), .rd_data_o(q_res), .rd_ready_i(b_ready)
  );
  mqttp_back u_back (
    .clk_i, .rst_ni, .in_valid_i(q_valid), .in_data_i(q_res), .in_ready_o(b_ready),
    .out_valid_o(b_valid), .out_data_o(b_res), .out_ready_i(m_axis_tready)
  );

  assign m_axis_tvalid = b_valid;
  assign m_axis_tlast = b_res.last;
  assign m_axis_tdata = {5'd0, b_res.byte_value, b_res.string_kind, b_res.field_value,
                         b_res.header_flags, b_res.packet_type, b_res.event_res};

  // Checks.
  `MCPP_ASSERT(a_no_drop, f_valid, q_ready, "front result dropped")
  `MCPP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
                    "output valid dropped under stall")
  `MCPP_ASSERT(a_lenerr_last, m_axis_tvalid && m_axis_tdata[3:0] == EV_LENERR,
               m_axis_tlast, "length error must end packet")
endmodule
